[rtl/sfq_pkg.sv]
// Shared types and codes for the searchable queue.
`default_nettype none

package sfq_pkg;

    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int FIELD_W = 5;
    localparam int IN_W    = 32;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic load_in;    // latch the incoming word, start scan at head
        logic exec_op;    // apply append/remove, set plain result
        logic scan_rd;    // read the entry under the scan pointer
        logic scan_next;  // step the scan pointer
        logic set_found;  // record a hit at the current scan position
        logic set_miss;   // record key not found
        logic put_out;    // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            occ_zero;
        logic            match;
        logic            scan_last;
        logic            out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/searchable_fifo_queue.sv]
// Top level: bounded FIFO queue with search by value.
// Append and remove, unused codes and a search of an empty queue pass through accept,
// execute and the load of the output register; a search of a non-empty queue is accepted,
// then compares entries from the head, up to the occupancy, until a hit or the last entry,
// and then loads the output register, as the scan reads one entry from the single-port
// entry memory and compares it in the next cycle. A new word is taken once the previous
// result has moved into the output register, which holds it until taken; while it is
// held, the next result waits and so does the word after it.
`default_nettype none

module searchable_fifo_queue
    import sfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output      logic                   o_ready,
    input  wire logic [OP_W-1:0]        i_operation,
    input  wire logic signed [IN_W-1:0] i_item_value,
    output      logic                   o_valid,
    input  wire logic                   i_ready,
    output      logic [ST_W-1:0]        o_status,
    output      logic [FIELD_W-1:0]     o_position,
    output      logic [FIELD_W-1:0]     o_entry_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sfq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_operation),
        .i_item_value  (i_item_value),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

[rtl/sfq_dpath.sv]
// Datapath: entry memory, pointers, scan logic and output register.
`default_nettype none

module sfq_dpath
    import sfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output      t_dp_sts            o_sts,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic signed [IN_W-1:0] i_item_value,
    input  wire logic               i_ready,
    output      logic               o_valid,
    output      logic [ST_W-1:0]    o_status,
    output      logic [FIELD_W-1:0] o_position,
    output      logic [FIELD_W-1:0] o_entry_count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = CNT_W + FIELD_W;
    localparam int KEY_W = VALUE_WIDTH + IN_W;

    logic [VALUE_WIDTH-1:0] r_mem [QUEUE_DEPTH];

    logic [OP_W-1:0]        r_op;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [IDX_W-1:0]       r_head;
    logic [IDX_W-1:0]       r_tail;
    logic [CNT_W-1:0]       r_occ;
    logic [IDX_W-1:0]       r_scan_idx;
    logic [CNT_W-1:0]       r_scan_cnt;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [ST_W-1:0]        r_status;
    logic [FIELD_W-1:0]     r_position;
    logic                   r_o_valid;
    logic [ST_W-1:0]        r_o_status;
    logic [FIELD_W-1:0]     r_o_position;
    logic [FIELD_W-1:0]     r_o_count;

    logic [KEY_W-1:0]       key_ext;
    logic [EXT_W-1:0]       pos_ext;
    logic [EXT_W-1:0]       occ_ext;
    logic [CNT_W:0]         cnt_inc;
    logic                   occ_full;
    logic                   mem_wr;

    // value zero-extended or cut to the stored width
    assign key_ext  = {{VALUE_WIDTH{1'b0}}, i_item_value};
    assign pos_ext  = {{FIELD_W{1'b0}}, r_scan_cnt} + 1'b1;
    assign occ_ext  = {{FIELD_W{1'b0}}, r_occ};
    assign cnt_inc  = {1'b0, r_scan_cnt} + 1'b1;
    assign occ_full = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign mem_wr   = i_cmd.exec_op && (r_op == OP_APPEND) && !occ_full;

    assign o_sts.op        = r_op;
    assign o_sts.occ_zero  = (r_occ == '0);
    assign o_sts.match     = (r_rd_data == r_key);
    assign o_sts.scan_last = (cnt_inc == {1'b0, r_occ});
    assign o_sts.out_free  = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_tail] <= r_key;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.exec_op) begin
                case (r_op)
                    OP_APPEND: begin
                        if (!occ_full) begin
                            r_tail <= (r_tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_tail + 1'b1;
                            r_occ  <= r_occ + 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_occ != '0) begin
                            r_head <= (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_head + 1'b1;
                            r_occ  <= r_occ - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.put_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= i_operation;
            r_key      <= key_ext[VALUE_WIDTH-1:0];
            r_scan_idx <= r_head;
            r_scan_cnt <= '0;
        end
        if (i_cmd.scan_next) begin
            r_scan_idx <= (r_scan_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_scan_idx + 1'b1;
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (i_cmd.exec_op) begin
            r_position <= '0;
            case (r_op)
                OP_APPEND: r_status <= occ_full ? ST_FULL : ST_OK;
                OP_REMOVE: r_status <= (r_occ == '0) ? ST_EMPTY : ST_OK;
                OP_SEARCH: r_status <= ST_NOT_FOUND;
                default:   r_status <= ST_OK;
            endcase
        end
        if (i_cmd.set_found) begin
            r_status   <= ST_OK;
            r_position <= pos_ext[FIELD_W-1:0];
        end
        if (i_cmd.set_miss) begin
            r_status   <= ST_NOT_FOUND;
            r_position <= '0;
        end
        if (i_cmd.put_out) begin
            r_o_status   <= r_status;
            r_o_position <= r_position;
            r_o_count    <= occ_ext[FIELD_W-1:0];
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_position    = r_o_position;
    assign o_entry_count = r_o_count;

endmodule

`default_nettype wire

[rtl/sfq_ctrl.sv]
// Controller: sequences one word through execute, scan and output.
`default_nettype none

module sfq_ctrl
    import sfq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output      logic    o_ready,
    input  wire t_dp_sts i_sts,
    output      t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // no word is taken while reset is held
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op == OP_SEARCH && !i_sts.occ_zero) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.exec_op = 1'b1;
                    n_state       = S_PUT;
                end
            end
            S_READ: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_PUT;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = S_PUT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_PUT: begin
                if (i_sts.out_free) begin
                    o_cmd.put_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the searchable FIFO queue: valid/ready driver and monitor.
`timescale 1ns / 100ps

module testbench;
    import sfq_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int TAIL_WAIT  = 40;    // wait after the last reply before the summary
    localparam int STALL_MAX  = 2000;  // cycles without any handshake
    localparam int RAND_WORDS = 500;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic signed [IN_W-1:0] value;
    } t_queue_word;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] entry_count;
    } t_queue_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [OP_W-1:0]        i_operation = '0;
    logic signed [IN_W-1:0] i_item_value = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [ST_W-1:0]        o_status;
    logic [FIELD_W-1:0]     o_position;
    logic [FIELD_W-1:0]     o_entry_count;

    searchable_fifo_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_item_value  (i_item_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the queue
    logic signed [IN_W-1:0] mirror_store [QDEPTH];
    logic [3:0]             mirror_head = '0;
    logic [3:0]             mirror_tail = '0;
    int                     mirror_count = 0;

    t_queue_word  words_to_send [$];
    t_queue_reply replies_due [$];
    t_queue_word  next_word;
    t_queue_reply got_reply;
    t_queue_reply due_reply;

    int words_sent = 0;
    int words_taken = 0;
    int total_words = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int send_calm = 0;
    int rx_stall = 0;
    int rx_calm = 0;
    int op_seen [4] = '{default: 0};
    int status_seen [4] = '{default: 0};

    function automatic t_queue_reply apply_queue_op(t_queue_word w);
        t_queue_reply r;
        logic [3:0]   slot;
        bit           hit;
        r.status = ST_OK;
        r.position = '0;
        case (w.op)
            OP_APPEND: begin
                if (mirror_count == QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_store[mirror_tail] = w.value;
                    mirror_tail = mirror_tail + 4'd1;
                    mirror_count++;
                end
            end
            OP_REMOVE: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    mirror_head = mirror_head + 4'd1;
                    mirror_count--;
                end
            end
            OP_SEARCH: begin
                slot = mirror_head;
                hit = 1'b0;
                for (int k = 0; k < mirror_count; k++) begin
                    if (!hit && mirror_store[slot] == w.value) begin
                        r.position = FIELD_W'(k + 1);
                        hit = 1'b1;
                    end
                    slot = slot + 4'd1;
                end
                if (!hit) r.status = ST_NOT_FOUND;
            end
            default: ;
        endcase
        r.entry_count = FIELD_W'(mirror_count);
        return r;
    endfunction

    // mostly back to back or short, now and then a long pause
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_word(logic [OP_W-1:0] op, logic signed [IN_W-1:0] value);
        t_queue_word w;
        w.op = op;
        w.value = value;
        words_to_send.push_back(w);
    endtask

    // driver and receiver, both moving on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && words_taken != words_sent)) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap = send_gap - 1;
                end else if (words_to_send.size() != 0) begin
                    next_word = words_to_send.pop_front();
                    i_operation <= next_word.op;
                    i_item_value <= next_word.value;
                    i_valid <= 1'b1;
                    words_sent <= words_sent + 1;
                    if (send_calm > 0) begin
                        send_calm = send_calm - 1;
                    end else begin
                        send_gap = idle_length();
                        if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 60);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end

            if (rx_stall > 0) begin
                i_ready <= 1'b0;
                rx_stall = rx_stall - 1;
            end else begin
                i_ready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm = rx_calm - 1;
                end else if ($urandom_range(0, 3) == 0) begin
                    rx_stall = idle_length();
                end else if ($urandom_range(0, 99) == 0) begin
                    rx_calm = $urandom_range(30, 120);
                end
            end
        end
    end

    // monitor: both handshakes on the rising edge, plus the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                next_word.op = i_operation;
                next_word.value = i_item_value;
                replies_due.push_back(apply_queue_op(next_word));
                op_seen[i_operation]++;
                words_taken <= words_taken + 1;
            end

            if (o_valid && i_ready) begin
                got_reply.status = o_status;
                got_reply.position = o_position;
                got_reply.entry_count = o_entry_count;
                status_seen[o_status]++;
                if (replies_due.size() == 0) begin
                    $display("%0t: reply with none due: status %0d position %0d count %0d",
                             $time, o_status, o_position, o_entry_count);
                    fail_count++;
                end else begin
                    due_reply = replies_due.pop_front();
                    if (got_reply.status !== due_reply.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, due_reply.status, got_reply.status);
                        fail_count++;
                    end
                    if (got_reply.position !== due_reply.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, due_reply.position, got_reply.position);
                        fail_count++;
                    end
                    if (got_reply.entry_count !== due_reply.entry_count) begin
                        $display("%0t: entry count expected %0d actual %0d",
                                 $time, due_reply.entry_count, got_reply.entry_count);
                        fail_count++;
                    end
                end
            end

            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else if (i_valid || words_to_send.size() != 0 || replies_due.size() != 0) begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= STALL_MAX) begin
                    $display("%0t: no handshake for %0d cycles", $time, STALL_MAX);
                    $display("testbench failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic signed [IN_W-1:0] key_pool [8];
        bit                     fill_phase;
        int                     r;
        logic [OP_W-1:0]        op;
        logic signed [IN_W-1:0] value;

        // directed: empty cases, extremes, fill to full, hit at both ends
        queue_word(OP_SEARCH, 32'sh0000_0000);
        queue_word(OP_REMOVE, 32'sh7FFF_FFFF);
        queue_word(OP_UNUSED, 32'sh8000_0000);
        queue_word(OP_APPEND, 32'sh8000_0000);
        queue_word(OP_APPEND, 32'sh7FFF_FFFF);
        queue_word(OP_APPEND, 32'sh0000_0000);
        queue_word(OP_APPEND, -32'sd1);
        queue_word(OP_APPEND, 32'sh5555_5555);
        queue_word(OP_APPEND, 32'shAAAA_AAAA);
        for (int i = 0; i < 8; i++) queue_word(OP_APPEND, $urandom);
        queue_word(OP_APPEND, 32'sh0000_0000);   // duplicate: first match must win
        queue_word(OP_APPEND, 32'sh1234_5678);
        queue_word(OP_APPEND, 32'sh0BAD_F00D);   // dropped, queue full
        queue_word(OP_SEARCH, 32'sh1234_5678);
        queue_word(OP_SEARCH, 32'sh8000_0000);
        queue_word(OP_SEARCH, 32'sh0000_0000);
        queue_word(OP_SEARCH, 32'sh0F0F_0F0F);
        queue_word(OP_UNUSED, -32'sd1);

        // random: alternate fill-heavy and drain-heavy runs so full and empty recur
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
        fill_phase = 1'b0;
        for (int n = 0; n < RAND_WORDS; n++) begin
            if ($urandom_range(0, 39) == 0) fill_phase = !fill_phase;
            r = $urandom_range(0, 99);
            if (fill_phase)
                op = (r < 60) ? OP_APPEND : (r < 75) ? OP_REMOVE : (r < 97) ? OP_SEARCH : OP_UNUSED;
            else
                op = (r < 15) ? OP_APPEND : (r < 60) ? OP_REMOVE : (r < 97) ? OP_SEARCH : OP_UNUSED;
            value = ($urandom_range(0, 99) < 65) ? key_pool[$urandom_range(0, 7)] : $urandom;
            queue_word(op, value);
        end
        total_words = words_to_send.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || words_taken != total_words
               || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("words: %0d appends, %0d removes, %0d searches, %0d unused codes",
                 op_seen[OP_APPEND], op_seen[OP_REMOVE], op_seen[OP_SEARCH],
                 op_seen[OP_UNUSED]);
        $display("replies: %0d ok, %0d empty, %0d full, %0d not found",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_NOT_FOUND]);
        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
